// ===== sv/whp_pkg.sv =====
// whp_pkg: types and constants shared by the wave header parser modules
// no dependencies
package whp_pkg;

  localparam int unsigned CLK_W   = 25;
  localparam int unsigned DVD_W   = 22;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned FC_W    = 7;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 25'd16000000;
  localparam logic [31:0] FMT_MAX_BYTES = 32'd100;
  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [FC_W-1:0] FC_MAX = 7'd127;
  localparam logic [FC_W-1:0] FC_HDR_LAST = 7'd11;
  localparam logic [FC_W-1:0] FC_ID_LAST = 7'd3;
  localparam logic [FC_W-1:0] FC_SIZE_LAST = 7'd7;
  localparam logic [FC_W-1:0] FC_FMT_TAG = 7'd0;
  localparam logic [FC_W-1:0] FC_FMT_CHAN = 7'd2;
  localparam logic [FC_W-1:0] FC_FMT_RATE_LO = 7'd4;
  localparam logic [FC_W-1:0] FC_FMT_RATE_HI = 7'd5;
  localparam logic [FC_W-1:0] FC_FMT_BITS = 7'd14;

  localparam logic [31:0] ID_WAVE = 32'h45564157;
  localparam logic [31:0] ID_FMT  = 32'h20746D66;
  localparam logic [31:0] ID_DATA = 32'h61746164;
  localparam logic [31:0] ID_LIST = 32'h5453494C;
  localparam logic [31:0] ID_FACT = 32'h74636166;

  localparam logic [7:0] FMT_PCM = 8'd1;
  localparam logic [7:0] CHAN_MONO = 8'd1;
  localparam logic [7:0] CHAN_STEREO = 8'd2;
  localparam logic [7:0] BITS_8 = 8'd8;
  localparam logic [7:0] BITS_16 = 8'd16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_WAIT,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_STAY,
    EV_HEADER,
    EV_CHUNK,
    EV_FMT,
    EV_SKIP,
    EV_WAIT,
    EV_DONE
  } event_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_FOUND,
    RES_BAD
  } res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_rsp_t;

  function automatic logic [FC_W-1:0] fc_inc(input logic [FC_W-1:0] fc);
    fc_inc = (fc == FC_MAX) ? fc : fc + 1'b1;
  endfunction

endpackage

// ===== sv/wave_header_parser_core.sv =====
// wave_header_parser_core: one byte item per cycle through the input queue unless the result
// register stalls; with the queue empty, the deciding byte item goes through a queue slot and
// the result register to out_tvalid. the last byte of a fmt chunk waits for the bit-serial rate
// divider; the queue takes up to QUEUE_DEPTH items meanwhile, then in_tready drops until the
// walker resumes. synchronous active-low reset: parser idle, queue empty, clock_hz back to 16000000.
// depends on whp_pkg, whp_front, whp_div, whp_back
module wave_header_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // data_size, rate_divider, channel_count, sample_bits, format_seen
  output logic        out_tuser,  // verdict
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [24:0] cfg_data
);

  logic [whp_pkg::CLK_W-1:0] clock_hz_r, clock_hz_nxt;
  logic                      q_valid, q_pop;
  whp_pkg::item_t            q_item;
  whp_pkg::div_req_t         div_req;
  whp_pkg::div_rsp_t         div_rsp;

  assign cfg_ready    = 1'b1;
  assign clock_hz_nxt = (cfg_valid && cfg_ready) ? cfg_data : clock_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= whp_pkg::CLOCK_HZ_RESET;
    end else begin
      clock_hz_r <= clock_hz_nxt;
    end
  end

  whp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  whp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  whp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clock_hz  (clock_hz_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== sv/whp_front.sv =====
// whp_front: input side, accepts byte items into a small register queue
// depends on whp_pkg
module whp_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  input  logic           in_tlast,
  output logic           q_valid,
  output whp_pkg::item_t q_item,
  input  logic           q_pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  whp_pkg::item_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_tready = (cnt_r != CNT_FULL);
  assign q_valid   = (cnt_r != '0);
  assign q_item    = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{data: in_tdata, first: in_tuser, last: in_tlast};
    end
  end

endmodule

// ===== sv/whp_div.sv =====
// whp_div: restoring divider, one quotient bit per cycle, low quotient byte out
// depends on whp_pkg
module whp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  whp_pkg::div_req_t req,
  output whp_pkg::div_rsp_t rsp
);

  localparam logic [whp_pkg::DIV_CNT_W-1:0] STEPS = whp_pkg::DIV_CNT_W'(whp_pkg::DVD_W);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [whp_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [whp_pkg::DVD_W-1:0]       num_r, num_nxt;
  logic [whp_pkg::RATE_W-1:0]      den_r, den_nxt;
  logic [whp_pkg::RATE_W-1:0]      rem_r, rem_nxt;
  logic [7:0]                      quot_r, quot_nxt;
  logic [whp_pkg::RATE_W:0]        rem_sh, rem_sub;
  logic                            ge;

  assign rem_sh  = {rem_r, num_r[whp_pkg::DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEPS;
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[whp_pkg::RATE_W-1:0] : rem_sh[whp_pkg::RATE_W-1:0];
      quot_nxt = {quot_r[6:0], ge};
      num_nxt  = {num_r[whp_pkg::DVD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp = '{done: done_r, quot: quot_r};

endmodule

// ===== sv/whp_back.sv =====
// whp_back: chunk walker, fmt checks and result register
// depends on whp_pkg and the whp_div handshake structs
module whp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [whp_pkg::CLK_W-1:0] clock_hz,
  input  logic                   q_valid,
  input  whp_pkg::item_t         q_item,
  output logic                   q_pop,
  output whp_pkg::div_req_t      div_req,
  input  whp_pkg::div_rsp_t      div_rsp,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata,
  output logic                   out_tuser
);

  whp_pkg::phase_t phase_r, phase_nxt, ph_b;
  whp_pkg::event_t ev;
  whp_pkg::res_t   res;

  logic [whp_pkg::FC_W-1:0]   fc_r, fc_nxt, fc_b;
  logic [31:0]                ws_r, ws_nxt, ws_b, ws_sh;
  logic [31:0]                cl_r, cl_nxt, cl_b;
  logic [31:0]                sk_r, sk_nxt, sk_b, sk_dec;
  logic [whp_pkg::RATE_W-1:0] sr_r, sr_nxt, sr_b;
  logic [7:0]                 dv_r, dv_nxt, dv_b;
  logic [1:0]                 ch_r, ch_nxt, ch_b;
  logic [4:0]                 bt_r, bt_nxt, bt_b;
  logic                       ff_r, ff_nxt, ff_b;
  logic                       pend_last_r, pend_last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [47:0]                out_data_r, out_data_nxt;
  logic                       out_user_r, out_user_nxt;
  logic                       out_free, active;
  logic [7:0]                 b;

  assign out_free = !out_valid_r || out_tready;
  assign b        = q_item.data;

  always_comb begin
    ph_b = q_item.first ? whp_pkg::PH_HEADER : phase_r;
    fc_b = q_item.first ? '0 : fc_r;
    ws_b = q_item.first ? '0 : ws_r;
    cl_b = q_item.first ? '0 : cl_r;
    sk_b = q_item.first ? '0 : sk_r;
    sr_b = q_item.first ? '0 : sr_r;
    dv_b = q_item.first ? '0 : dv_r;
    ch_b = q_item.first ? '0 : ch_r;
    bt_b = q_item.first ? '0 : bt_r;
    ff_b = q_item.first ? 1'b0 : ff_r;
  end

  assign ws_sh  = {b, ws_b[31:8]};
  assign sk_dec = sk_b - 1'b1;

  // datapath update and classification of the current item, or capture of the divider result
  always_comb begin
    fc_nxt = fc_r;
    ws_nxt = ws_r;
    cl_nxt = cl_r;
    sk_nxt = sk_r;
    sr_nxt = sr_r;
    dv_nxt = dv_r;
    ch_nxt = ch_r;
    bt_nxt = bt_r;
    ff_nxt = ff_r;
    pend_last_nxt = pend_last_r;
    res    = whp_pkg::RES_NONE;
    ev     = whp_pkg::EV_STAY;
    q_pop  = 1'b0;
    active = 1'b0;
    div_req = '{start: 1'b0, dividend: clock_hz[whp_pkg::CLK_W-1:3], divisor: sr_r};
    if (phase_r == whp_pkg::PH_WAIT) begin
      if (div_rsp.done) begin
        dv_nxt = div_rsp.quot - 1'b1;
        ch_nxt = ws_r[1:0];
        bt_nxt = ws_r[12:8];
        ff_nxt = 1'b1;
        if (pend_last_r) begin
          res = whp_pkg::RES_BAD;
          ev  = whp_pkg::EV_DONE;
        end else begin
          ev     = whp_pkg::EV_CHUNK;
          fc_nxt = '0;
          ws_nxt = '0;
        end
      end
    end else if (q_valid && out_free) begin
      q_pop  = 1'b1;
      fc_nxt = fc_b;
      ws_nxt = ws_b;
      cl_nxt = cl_b;
      sk_nxt = sk_b;
      sr_nxt = sr_b;
      dv_nxt = dv_b;
      ch_nxt = ch_b;
      bt_nxt = bt_b;
      ff_nxt = ff_b;
      if (q_item.first) begin
        ev = whp_pkg::EV_HEADER;
      end
      case (ph_b)
        whp_pkg::PH_HEADER: begin
          active = 1'b1;
          ws_nxt = ws_sh;
          if (fc_b == whp_pkg::FC_HDR_LAST) begin
            if (ws_sh != whp_pkg::ID_WAVE) begin
              res = whp_pkg::RES_BAD;
            end else begin
              ev     = whp_pkg::EV_CHUNK;
              fc_nxt = '0;
              ws_nxt = '0;
            end
          end else begin
            fc_nxt = whp_pkg::fc_inc(fc_b);
          end
        end
        whp_pkg::PH_CHUNK: begin
          active = 1'b1;
          if (fc_b == whp_pkg::FC_ID_LAST) begin
            cl_nxt = ws_sh;
            ws_nxt = '0;
            fc_nxt = whp_pkg::fc_inc(fc_b);
          end else if (fc_b < whp_pkg::FC_SIZE_LAST) begin
            ws_nxt = ws_sh;
            fc_nxt = whp_pkg::fc_inc(fc_b);
          end else begin
            cl_nxt = ws_sh;
            fc_nxt = '0;
            ws_nxt = '0;
            if (cl_b == whp_pkg::ID_DATA) begin
              res = whp_pkg::RES_FOUND;
            end else if (cl_b == whp_pkg::ID_FMT) begin
              if (ws_sh > whp_pkg::FMT_MAX_BYTES || ws_sh < whp_pkg::FMT_MIN_BYTES) begin
                res = whp_pkg::RES_BAD;
              end else begin
                sk_nxt = ws_sh;
                sr_nxt = '0;
                ev     = whp_pkg::EV_FMT;
              end
            end else if (cl_b inside {whp_pkg::ID_LIST, whp_pkg::ID_FACT}) begin
              sk_nxt = ws_sh;
              ev     = (ws_sh == '0) ? whp_pkg::EV_CHUNK : whp_pkg::EV_SKIP;
            end else begin
              res = whp_pkg::RES_BAD;
            end
          end
        end
        whp_pkg::PH_FMT: begin
          active = 1'b1;
          case (fc_b)
            whp_pkg::FC_FMT_TAG: begin
              if (b != whp_pkg::FMT_PCM) res = whp_pkg::RES_BAD;
            end
            whp_pkg::FC_FMT_CHAN: begin
              if (!(b inside {whp_pkg::CHAN_MONO, whp_pkg::CHAN_STEREO})) begin
                res = whp_pkg::RES_BAD;
              end
              ws_nxt = {ws_b[31:2], b[1:0]};
            end
            whp_pkg::FC_FMT_RATE_LO: sr_nxt = {sr_b[15:8], b};
            whp_pkg::FC_FMT_RATE_HI: sr_nxt = {b, sr_b[7:0]};
            whp_pkg::FC_FMT_BITS: begin
              if (!(b inside {whp_pkg::BITS_8, whp_pkg::BITS_16})) begin
                res = whp_pkg::RES_BAD;
              end
              ws_nxt = {ws_b[31:13], b[4:0], ws_b[7:0]};
            end
            default: begin
            end
          endcase
          fc_nxt = whp_pkg::fc_inc(fc_b);
          sk_nxt = sk_dec;
          if (res == whp_pkg::RES_NONE && sk_dec == '0) begin
            if (sr_nxt == '0) begin
              res = whp_pkg::RES_BAD;
            end else begin
              div_req.start   = 1'b1;
              div_req.divisor = sr_nxt;
              pend_last_nxt   = q_item.last;
              ev              = whp_pkg::EV_WAIT;
            end
          end
        end
        whp_pkg::PH_SKIP: begin
          active = 1'b1;
          if (sk_b != '0) sk_nxt = sk_dec;
          if (sk_b == '0 || sk_dec == '0) begin
            ev     = whp_pkg::EV_CHUNK;
            fc_nxt = '0;
            ws_nxt = '0;
          end
        end
        default: begin
        end
      endcase
      if (active && res == whp_pkg::RES_NONE && q_item.last && ev != whp_pkg::EV_WAIT) begin
        res = whp_pkg::RES_BAD;
      end
      if (res != whp_pkg::RES_NONE) begin
        ev = whp_pkg::EV_DONE;
      end
    end
  end

  // next phase
  always_comb begin
    case (ev)
      whp_pkg::EV_STAY:   phase_nxt = phase_r;
      whp_pkg::EV_HEADER: phase_nxt = whp_pkg::PH_HEADER;
      whp_pkg::EV_CHUNK:  phase_nxt = whp_pkg::PH_CHUNK;
      whp_pkg::EV_FMT:    phase_nxt = whp_pkg::PH_FMT;
      whp_pkg::EV_SKIP:   phase_nxt = whp_pkg::PH_SKIP;
      whp_pkg::EV_WAIT:   phase_nxt = whp_pkg::PH_WAIT;
      whp_pkg::EV_DONE:   phase_nxt = whp_pkg::PH_DONE;
      default:            phase_nxt = phase_r;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res != whp_pkg::RES_NONE) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = (res == whp_pkg::RES_BAD);
      out_data_nxt  = {ff_nxt, bt_nxt, ch_nxt, dv_nxt,
                       (res == whp_pkg::RES_FOUND) ? cl_nxt : 32'd0};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= whp_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
      fc_r        <= '0;
      ws_r        <= '0;
      cl_r        <= '0;
      sk_r        <= '0;
      sr_r        <= '0;
      dv_r        <= '0;
      ch_r        <= '0;
      bt_r        <= '0;
      ff_r        <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      fc_r        <= fc_nxt;
      ws_r        <= ws_nxt;
      cl_r        <= cl_nxt;
      sk_r        <= sk_nxt;
      sr_r        <= sr_nxt;
      dv_r        <= dv_nxt;
      ch_r        <= ch_nxt;
      bt_r        <= bt_nxt;
      ff_r        <= ff_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== test/testbench.sv =====
// testbench for wave_header_parser_core: streams WAVE file headers byte by byte, predicts each
// verdict in-bench or takes it from the directed row, and checks every result item field by field
// depends on whp_pkg and wave_header_parser_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        verdict;
    logic [31:0] size;
    logic [7:0]  divider;
    logic [1:0]  channels;
    logic [4:0]  bits;
    logic        fmt_seen;
  } header_verdict_t;

  typedef struct {
    logic [31:0]     wave_id;
    int              fmt_count;
    logic [31:0]     fmt_size;
    logic [7:0]      tag;
    logic [7:0]      chan;
    logic [7:0]      bits;
    logic [15:0]     rate;
    int              skips;
    int              skip_max;
    logic [31:0]     tail_id;
    logic [31:0]     data_size;
    int              cut;
    bit              drop;
    int              junk;
    bit              typed;
    header_verdict_t want;
  } file_spec_t;

  localparam header_verdict_t BAD_BARE = '{verdict: 1'b1, default: '0};
  localparam header_verdict_t NONE_YET = '0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // first_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // data_size, rate_divider, channel_count, sample_bits, format_seen
  logic        out_tuser;  // verdict
  logic        cfg_valid;
  logic        cfg_ready;
  logic [24:0] cfg_data;

  // parser model state
  logic [24:0]      clock_model;
  whp_pkg::phase_t  ph;
  logic [6:0]       fcnt;
  logic [31:0]      shreg;
  logic [31:0]      clen;
  logic [31:0]      remain;
  logic [15:0]      rate_m;
  logic [7:0]       div_m;
  logic [1:0]       chan_m;
  logic [4:0]       bits_m;
  logic             fmt_ok_m;

  header_verdict_t pending_verdicts[$];
  logic [7:0]      file_bytes[$];
  bit              row_typed;
  header_verdict_t row_want;
  int              items_taken;
  int              mismatches;
  int              send_calm;

  file_spec_t dir_rows [22] = '{
    '{whp_pkg::ID_WAVE, 0, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd0, 0, 1'b0, 0, 1'b1, '{1'b0, 32'd0, 8'd0, 2'd0, 5'd0, 1'b0}},
    '{whp_pkg::ID_WAVE, 0, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'hFFFFFFFF, 0, 1'b0, 4, 1'b1,
      '{1'b0, 32'hFFFFFFFF, 8'd0, 2'd0, 5'd0, 1'b0}},
    '{32'h65564157, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 0, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      32'h6B6E756A, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd15,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd101,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd77, 0, 1'b0, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 1, 32'd100,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_STEREO, whp_pkg::BITS_16, 16'd44100, 2, 5,
      whp_pkg::ID_DATA, 32'd512, 0, 1'b0, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      8'd0, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, 8'd0, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, 8'd3, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, 8'd12, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd0, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 0, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_16, 16'd1, 0, 0,
      whp_pkg::ID_DATA, 32'd3, 0, 1'b0, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_STEREO, whp_pkg::BITS_16, 16'hFFFF, 0, 0,
      whp_pkg::ID_DATA, 32'd4, 0, 1'b0, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 0, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 3, 0,
      whp_pkg::ID_DATA, 32'd1234, 0, 1'b0, 0, 1'b1,
      '{1'b0, 32'd1234, 8'd0, 2'd0, 5'd0, 1'b0}},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 6, 1'b0, 0, 1'b1, BAD_BARE},
    '{whp_pkg::ID_WAVE, 0, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_8, 16'd8000, 0, 0,
      whp_pkg::ID_DATA, 32'h10000, -1, 1'b0, 0, 1'b1,
      '{1'b0, 32'h10000, 8'd0, 2'd0, 5'd0, 1'b0}},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_STEREO, whp_pkg::BITS_8, 16'd11025, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 36, 1'b0, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 1, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_STEREO, whp_pkg::BITS_8, 16'd11025, 0, 0,
      whp_pkg::ID_DATA, 32'd9, 28, 1'b1, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 2, 32'd16,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_MONO, whp_pkg::BITS_16, 16'd16000, 1, 3,
      whp_pkg::ID_DATA, 32'd88, 0, 1'b0, 0, 1'b0, NONE_YET},
    '{whp_pkg::ID_WAVE, 1, 32'd40,
      whp_pkg::FMT_PCM, whp_pkg::CHAN_STEREO, whp_pkg::BITS_8, 16'd22050, 2, 6,
      whp_pkg::ID_DATA, 32'd640, 0, 1'b0, 3, 1'b0, NONE_YET}
  };

  wave_header_parser_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 80);
    return $urandom_range(0, 10);
  endfunction

  function automatic void clear_walk();
    fcnt = '0;
    shreg = '0;
    clen = '0;
    remain = '0;
    rate_m = '0;
    div_m = '0;
    chan_m = '0;
    bits_m = '0;
    fmt_ok_m = 1'b0;
  endfunction

  function automatic void advance_offset();
    if (fcnt != whp_pkg::FC_MAX) fcnt++;
  endfunction

  function automatic void enter_chunk();
    ph = whp_pkg::PH_CHUNK;
    fcnt = '0;
    shreg = '0;
  endfunction

  function automatic whp_pkg::res_t walk_byte(input logic [7:0] b);
    logic [31:0] id;
    logic [31:0] q;
    case (ph)
      whp_pkg::PH_HEADER: begin
        shreg = {b, shreg[31:8]};
        if (fcnt == whp_pkg::FC_HDR_LAST) begin
          if (shreg != whp_pkg::ID_WAVE) return whp_pkg::RES_BAD;
          enter_chunk();
          return whp_pkg::RES_NONE;
        end
        advance_offset();
        return whp_pkg::RES_NONE;
      end
      whp_pkg::PH_CHUNK: begin
        shreg = {b, shreg[31:8]};
        if (fcnt == whp_pkg::FC_ID_LAST) begin
          clen = shreg;
          shreg = '0;
          advance_offset();
          return whp_pkg::RES_NONE;
        end
        if (fcnt < whp_pkg::FC_SIZE_LAST) begin
          advance_offset();
          return whp_pkg::RES_NONE;
        end
        id = clen;
        clen = shreg;
        fcnt = '0;
        shreg = '0;
        if (id == whp_pkg::ID_DATA) return whp_pkg::RES_FOUND;
        if (id == whp_pkg::ID_FMT) begin
          if (clen > whp_pkg::FMT_MAX_BYTES || clen < whp_pkg::FMT_MIN_BYTES) begin
            return whp_pkg::RES_BAD;
          end
          remain = clen;
          rate_m = '0;
          ph = whp_pkg::PH_FMT;
          return whp_pkg::RES_NONE;
        end
        if (id == whp_pkg::ID_LIST || id == whp_pkg::ID_FACT) begin
          remain = clen;
          if (clen == 0) enter_chunk();
          else ph = whp_pkg::PH_SKIP;
          return whp_pkg::RES_NONE;
        end
        return whp_pkg::RES_BAD;
      end
      whp_pkg::PH_FMT: begin
        case (fcnt)
          whp_pkg::FC_FMT_TAG: if (b != whp_pkg::FMT_PCM) return whp_pkg::RES_BAD;
          whp_pkg::FC_FMT_CHAN: begin
            if (b != whp_pkg::CHAN_MONO && b != whp_pkg::CHAN_STEREO) return whp_pkg::RES_BAD;
            shreg[1:0] = b[1:0];
          end
          whp_pkg::FC_FMT_RATE_LO: rate_m[7:0] = b;
          whp_pkg::FC_FMT_RATE_HI: rate_m[15:8] = b;
          whp_pkg::FC_FMT_BITS: begin
            if (b != whp_pkg::BITS_8 && b != whp_pkg::BITS_16) return whp_pkg::RES_BAD;
            shreg[12:8] = b[4:0];
          end
          default: ;
        endcase
        advance_offset();
        remain--;
        if (remain == 0) begin
          if (rate_m == 0) return whp_pkg::RES_BAD;
          q = ({7'd0, clock_model} >> 3) / {16'd0, rate_m};
          div_m = q[7:0] - 8'd1;
          chan_m = shreg[1:0];
          bits_m = shreg[12:8];
          fmt_ok_m = 1'b1;
          enter_chunk();
        end
        return whp_pkg::RES_NONE;
      end
      whp_pkg::PH_SKIP: begin
        if (remain != 0) remain--;
        if (remain == 0) enter_chunk();
        return whp_pkg::RES_NONE;
      end
      default: return whp_pkg::RES_NONE;
    endcase
  endfunction

  // advance the model by one accepted item, queue the verdict it decides
  task automatic take_item(input logic [7:0] b, input logic f, input logic l, output bit used);
    whp_pkg::res_t   r;
    header_verdict_t v;
    used = 1'b0;
    if (f) begin
      clear_walk();
      ph = whp_pkg::PH_HEADER;
    end
    if (ph == whp_pkg::PH_IDLE || ph == whp_pkg::PH_DONE) return;
    used = 1'b1;
    r = walk_byte(b);
    if (r == whp_pkg::RES_NONE && l) r = whp_pkg::RES_BAD;
    if (r == whp_pkg::RES_NONE) return;
    v.verdict = (r == whp_pkg::RES_BAD);
    v.size = (r == whp_pkg::RES_FOUND) ? clen : 32'd0;
    v.divider = div_m;
    v.channels = chan_m;
    v.bits = bits_m;
    v.fmt_seen = fmt_ok_m;
    ph = whp_pkg::PH_DONE;
    pending_verdicts.push_back(row_typed ? row_want : v);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    int gap;
    bit used;
    gap = draw_gap(send_calm);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata = 8'($urandom);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = d;
    in_tuser = f;
    in_tlast = l;
    do @(posedge clk); while (in_tready !== 1'b1);
    take_item(d, f, l, used);
    if (used) items_taken++;
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_fmt(input logic [31:0] size, input logic [7:0] tag, input logic [7:0] chan,
                         input logic [7:0] bits, input logic [15:0] rate);
    put_word(whp_pkg::ID_FMT);
    put_word(size);
    if (size >= whp_pkg::FMT_MIN_BYTES && size <= whp_pkg::FMT_MAX_BYTES) begin
      for (int i = 0; i < size; i++) begin
        case (7'(i))
          whp_pkg::FC_FMT_TAG:     file_bytes.push_back(tag);
          whp_pkg::FC_FMT_CHAN:    file_bytes.push_back(chan);
          whp_pkg::FC_FMT_RATE_LO: file_bytes.push_back(rate[7:0]);
          whp_pkg::FC_FMT_RATE_HI: file_bytes.push_back(rate[15:8]);
          whp_pkg::FC_FMT_BITS:    file_bytes.push_back(bits);
          default:                 file_bytes.push_back(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic put_skip(input int skip_max);
    int n;
    n = (skip_max == 0) ? 0 : $urandom_range(0, skip_max);
    put_word($urandom_range(0, 1) ? whp_pkg::ID_LIST : whp_pkg::ID_FACT);
    put_word(n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic send_file(input file_spec_t s);
    int split;
    int n;
    int last_at;
    file_bytes.delete();
    put_word($urandom);
    put_word($urandom);
    put_word(s.wave_id);
    split = $urandom_range(0, s.skips);
    repeat (split) put_skip(s.skip_max);
    for (int k = 0; k < s.fmt_count; k++) begin
      if (k == 0) put_fmt(s.fmt_size, s.tag, s.chan, s.bits, s.rate);
      else put_fmt($urandom_range(16, 24), whp_pkg::FMT_PCM,
                   $urandom_range(0, 1) ? whp_pkg::CHAN_STEREO : whp_pkg::CHAN_MONO,
                   $urandom_range(0, 1) ? whp_pkg::BITS_16 : whp_pkg::BITS_8,
                   16'($urandom_range(1, 65535)));
    end
    repeat (s.skips - split) put_skip(s.skip_max);
    put_word(s.tail_id);
    put_word(s.data_size);
    n = file_bytes.size();
    last_at = (s.cut > 0) ? s.cut - 1 : (s.cut < 0 ? n + s.cut : -1);
    if (last_at >= n) last_at = -1;
    if (last_at >= 0) n = last_at + 1;
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0, i == last_at && !s.drop);
    repeat (s.junk) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  function automatic file_spec_t random_file();
    file_spec_t s;
    s.wave_id = whp_pkg::ID_WAVE;
    s.fmt_count = ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 7) == 0 ? 2 : 1);
    s.fmt_size = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 100) : 16;
    s.tag = whp_pkg::FMT_PCM;
    s.chan = $urandom_range(0, 1) ? whp_pkg::CHAN_STEREO : whp_pkg::CHAN_MONO;
    s.bits = $urandom_range(0, 1) ? whp_pkg::BITS_16 : whp_pkg::BITS_8;
    s.rate = 16'($urandom_range(1, 65535));
    s.skips = $urandom_range(0, 2);
    s.skip_max = $urandom_range(0, 6);
    s.tail_id = whp_pkg::ID_DATA;
    s.data_size = $urandom;
    s.cut = 0;
    s.drop = 1'b0;
    s.junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    s.typed = 1'b0;
    s.want = NONE_YET;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 9))
        0: s.wave_id = s.wave_id ^ (32'd1 << $urandom_range(0, 31));
        1: begin s.fmt_count = 1; s.tag = 8'($urandom); end
        2: begin s.fmt_count = 1; s.chan = 8'($urandom); end
        3: begin s.fmt_count = 1; s.bits = 8'($urandom); end
        4: begin s.fmt_count = 1; s.rate = '0; end
        5: begin
          s.fmt_count = 1;
          s.fmt_size = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(101, 255);
        end
        6: s.tail_id = $urandom;
        7: s.cut = $urandom_range(1, 60);
        8: begin s.cut = $urandom_range(1, 60); s.drop = 1'b1; end
        default: s.cut = -1;
      endcase
    end
    return s;
  endfunction

  // let every queued verdict drain, then allow for a fmt division still in flight
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_clock(input logic [24:0] hz);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = hz;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    clock_model = hz;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int byte_goal);
    int start_items;
    start_items = items_taken;
    while (items_taken - start_items < byte_goal) send_file(random_file());
  endtask

  function automatic void compare_field(input string what, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
    end
  endfunction

  initial begin : result_sink
    header_verdict_t got;
    header_verdict_t want;
    int stall;
    int calm;
    calm = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap(calm);
      repeat (stall) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got = '{out_tuser, out_tdata[31:0], out_tdata[39:32], out_tdata[41:40],
              out_tdata[46:42], out_tdata[47]};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, expected none actual %h", $time, got);
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("verdict", want.verdict, got.verdict);
        compare_field("data_size", want.size, got.size);
        compare_field("rate_divider", want.divider, got.divider);
        compare_field("channel_count", want.channels, got.channels);
        compare_field("sample_bits", want.bits, got.bits);
        compare_field("format_seen", want.fmt_seen, got.fmt_seen);
      end
    end
  end

  initial begin
    logic [24:0] hz;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = whp_pkg::CLOCK_HZ_RESET;
    clock_model = whp_pkg::CLOCK_HZ_RESET;
    ph = whp_pkg::PH_IDLE;
    clear_walk();
    row_typed = 1'b0;
    row_want = NONE_YET;
    items_taken = 0;
    mismatches = 0;
    send_calm = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // stray bytes before any file start are dropped by the parser
    repeat (5) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_want = dir_rows[i].want;
      send_file(dir_rows[i]);
    end
    row_typed = 1'b0;

    for (int k = 0; k < 4; k++) begin
      settle();
      hz = (k == 0) ? 25'd1000000 :
           (k == 1) ? 25'd32000000 : 25'($urandom_range(1000000, 32000000));
      write_clock(hz);
      run_random(150);
    end
    settle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
